>>> rtl/sftr_pkg.sv
// Shared types, constants and helpers of the scan pixel flat-field, tone and recolor unit.
`default_nettype none

package sftr_pkg;

  // Luma fraction bits; ONE_Q stands for 1.0.
  localparam int FRAC_BITS = 12;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int HALF_Q    = 1 << (FRAC_BITS - 1);

  // Q1.8 weights, 256 stands for 1.0.
  localparam logic [8:0] W_FULL = 9'd256;

  // Flat-field division operands.
  localparam int LM_W  = 18;
  localparam int DEN_W = 18;
  localparam int NUM_W = FRAC_BITS + 18;

  // Reciprocal of 255 for the luma to fraction conversion: x / 255 = (x * C) >> K.
  localparam int RECIP_K = 32;
  localparam logic [24:0] RECIP_C = 25'd16843010;
  localparam int XW   = FRAC_BITS + 8;
  localparam int RP_W = XW + 25;

  // Restoring divider layout.
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

  // Register map indexes.
  localparam logic [2:0] REG_FLAT    = 3'd0;
  localparam logic [2:0] REG_BLACK   = 3'd1;
  localparam logic [2:0] REG_GAIN    = 3'd2;
  localparam logic [2:0] REG_MIX     = 3'd3;
  localparam logic [2:0] REG_RECOLOR = 3'd4;
  localparam logic [2:0] REG_MODE    = 3'd5;
  localparam logic [2:0] REG_PAPER   = 3'd6;
  localparam logic [2:0] REG_INK     = 3'd7;

  // Pixel color: index 0 blue, 1 green, 2 red, as in the packed tints.
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [8:0]  flat;
    logic [11:0] black;
    logic [17:0] gain;
    logic [8:0]  mix;
    logic [8:0]  recolor;
    logic [1:0]  mode;
    rgb_t        paper;
    rgb_t        ink;
  } cfg_t;

  function automatic logic [8:0] sat256(input logic [8:0] w);
    return (w > W_FULL) ? W_FULL : w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sftr_front.sv
// Front stages: luma to fraction conversion and flat-field dividend, divisor and overflow.
`default_nettype none

module sftr_front
  import sftr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       luma,
  input  logic [7:0]       backdrop,
  input  rgb_t             src,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [NUM_W-1:0] num,
  output logic [DEN_W-1:0] den,
  output logic             ovf,
  output logic [Q_W-1:0]   work0,
  output rgb_t             rgb
);

  logic v1_r, v2_r;
  logic en1, en2;

  logic [LM_W-1:0]  lum1000;
  logic [DEN_W-1:0] den1;
  logic [XW-1:0]    xin;
  logic [RP_W-1:0]  rprod;

  logic [LM_W-1:0]  lum1000_r;
  logic [DEN_W-1:0] den1_r;
  logic [Q_W-1:0]   w01_r;
  rgb_t             rgb1_r;

  logic [NUM_W-1:0] num2;
  logic [NUM_W-1:0] dsh2;

  logic [NUM_W-1:0] num2_r;
  logic [DEN_W-1:0] den2_r;
  logic             ovf2_r;
  logic [Q_W-1:0]   w02_r;
  rgb_t             rgb2_r;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // First stage: scaled luma, divisor, and luma / 255 by reciprocal.
  assign lum1000 = {10'd0, luma} * LM_W'(1000);
  assign den1    = {10'd0, backdrop} * DEN_W'(1000) + DEN_W'(255);
  assign xin     = {luma, {FRAC_BITS{1'b0}}} + XW'(127);
  assign rprod   = RP_W'(xin) * RP_W'(RECIP_C);

  // Second stage: rounded dividend and the test for a quotient of one or more.
  assign num2 = {lum1000_r, {FRAC_BITS{1'b0}}} + NUM_W'(den1_r >> 1);
  assign dsh2 = {den1_r, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      lum1000_r <= lum1000;
      den1_r    <= den1;
      w01_r     <= rprod[RECIP_K +: Q_W];
      rgb1_r    <= src;
    end
    if (en2) begin
      num2_r <= num2;
      den2_r <= den1_r;
      ovf2_r <= (num2 >= dsh2);
      w02_r  <= w01_r;
      rgb2_r <= rgb1_r;
    end
  end

  assign out_valid = v2_r;
  assign num       = num2_r;
  assign den       = den2_r;
  assign ovf       = ovf2_r;
  assign work0     = w02_r;
  assign rgb       = rgb2_r;

endmodule

`default_nettype wire

>>> rtl/sftr_div.sv
// Pipelined restoring divider for the flat-field quotient, a few quotient bits per stage.
`default_nettype none

module sftr_div
  import sftr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic             ovf,
  input  logic [Q_W-1:0]   work0_in,
  input  rgb_t             rgb_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Q_W-1:0]   corr,
  output logic [Q_W-1:0]   work0_out,
  output rgb_t             rgb_out
);

  localparam int LAST = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES-1:0] en;
  logic [DIV_STAGES-1:0] ovf_r;

  logic [NUM_W-1:0]     rem_r [DIV_STAGES];
  logic [FRAC_BITS-1:0] q_r   [DIV_STAGES];
  logic [DEN_W-1:0]     den_r [DIV_STAGES];
  logic [Q_W-1:0]       w0_r  [DIV_STAGES];
  rgb_t                 rgb_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                 v_i;
    logic [NUM_W-1:0]     rem_i, rem_o, trial;
    logic [FRAC_BITS-1:0] q_i, q_o;
    logic [DEN_W-1:0]     den_i;
    logic                 ovf_i;
    logic [Q_W-1:0]       w0_i;
    rgb_t                 rgb_i;

    if (s == 0) begin : g_head
      assign v_i   = in_valid;
      assign rem_i = num;
      assign q_i   = '0;
      assign den_i = den;
      assign ovf_i = ovf;
      assign w0_i  = work0_in;
      assign rgb_i = rgb_in;
    end else begin : g_body
      assign v_i   = v_r[s-1];
      assign rem_i = rem_r[s-1];
      assign q_i   = q_r[s-1];
      assign den_i = den_r[s-1];
      assign ovf_i = ovf_r[s-1];
      assign w0_i  = w0_r[s-1];
      assign rgb_i = rgb_r[s-1];
    end

    if (s == LAST) begin : g_tail
      assign en[s] = !v_r[s] || out_ready;
    end else begin : g_mid
      assign en[s] = !v_r[s] || en[s+1];
    end

    // Quotient bits from the top down; the dividend is known to be below den << FRAC_BITS
    // unless the overflow flag is set, in which case the quotient is ignored.
    always_comb begin
      rem_o = rem_i;
      q_o   = q_i;
      trial = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (s * DIV_STEPS + k < FRAC_BITS) begin
          trial = NUM_W'(den_i) << (FRAC_BITS - 1 - (s * DIV_STEPS + k));
          if (rem_o >= trial) begin
            rem_o = rem_o - trial;
            q_o[FRAC_BITS - 1 - (s * DIV_STEPS + k)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_o;
        q_r[s]   <= q_o;
        den_r[s] <= den_i;
        ovf_r[s] <= ovf_i;
        w0_r[s]  <= w0_i;
        rgb_r[s] <= rgb_i;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[LAST];
  assign corr      = ovf_r[LAST] ? ONE_Q : {1'b0, q_r[LAST]};
  assign work0_out = w0_r[LAST];
  assign rgb_out   = rgb_r[LAST];

endmodule

`default_nettype wire

>>> rtl/sftr_tone.sv
// Flat-field blend followed by the optional black point stretch and smoothstep mix.
`default_nettype none

module sftr_tone
  import sftr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  cfg_t           cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [Q_W-1:0] corr,
  input  logic [Q_W-1:0] work0,
  input  rgb_t           rgb_in,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [Q_W-1:0] work,
  output rgb_t           rgb_out
);

  localparam int FW  = Q_W + 9;
  localparam int PW  = Q_W + 18;
  localparam int TW  = FRAC_BITS + 2;
  localparam int SMW = Q_W + TW;

  logic [4:0] v_r;
  logic [4:0] en;

  // Stage 0: flat-field blend.
  logic [8:0]    s_w;
  logic [FW-1:0] fsum;
  logic [Q_W-1:0] w0_r;
  rgb_t           rgb0_r;

  // Stage 1: black point subtraction and gain.
  logic [FRAC_BITS+12:0] bp_sum;
  logic [FRAC_BITS-1:0]  bp;
  logic [Q_W-1:0]        d1;
  logic [PW-1:0]         prod1_r;
  logic [Q_W-1:0]        w1_r;
  rgb_t                  rgb1_r;

  // Stage 2: round and cap, square, and 3 - 2x.
  logic [PW:0]       xs_sum;
  logic [PW-8:0]     xs;
  logic [Q_W-1:0]    x2;
  logic [Q_W-1:0]    x2_r;
  logic [2*Q_W-1:0]  sqp2_r;
  logic [TW-1:0]     t2_r;
  logic [Q_W-1:0]    w2_r;
  rgb_t              rgb2_r;

  // Stage 3: rounded square times 3 - 2x.
  logic [2*Q_W:0]    sq_sum;
  logic [Q_W-1:0]    sq3;
  logic [Q_W-1:0]    x3_r;
  logic [SMW-1:0]    smp3_r;
  logic [Q_W-1:0]    w3_r;
  rgb_t              rgb3_r;

  // Stage 4: smoothstep mix and tone bypass.
  logic [SMW:0]      sm_sum;
  logic [Q_W-1:0]    sm4;
  logic [8:0]        k_w;
  logic [FW-1:0]     bsum;
  logic [Q_W-1:0]    w4_r;
  rgb_t              rgb4_r;

  assign en[4] = !v_r[4] || out_ready;
  assign en[3] = !v_r[3] || en[4];
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign in_ready = en[0];

  assign s_w  = sat256(cfg.flat);
  assign fsum = FW'(work0) * FW'(W_FULL - s_w) + FW'(corr) * FW'(s_w) + FW'(128);

  assign bp_sum = {1'b0, cfg.black, {FRAC_BITS{1'b0}}} + (FRAC_BITS + 13)'(2048);
  assign bp     = bp_sum[12 +: FRAC_BITS];
  assign d1     = (w0_r > {1'b0, bp}) ? (w0_r - {1'b0, bp}) : '0;

  assign xs_sum = {1'b0, prod1_r} + (PW + 1)'(128);
  assign xs     = xs_sum[PW:8];
  assign x2     = (xs > (PW - 7)'(ONE_Q)) ? ONE_Q : xs[Q_W-1:0];

  assign sq_sum = {1'b0, sqp2_r} + (2 * Q_W + 1)'(HALF_Q);
  assign sq3    = sq_sum[FRAC_BITS +: Q_W];

  assign sm_sum = {1'b0, smp3_r} + (SMW + 1)'(HALF_Q);
  assign sm4    = sm_sum[FRAC_BITS +: Q_W];
  assign k_w    = sat256(cfg.mix);
  assign bsum   = FW'(x3_r) * FW'(W_FULL - k_w) + FW'(sm4) * FW'(k_w) + FW'(128);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      w0_r   <= fsum[8 +: Q_W];
      rgb0_r <= rgb_in;
    end
    if (en[1]) begin
      prod1_r <= PW'(d1) * PW'(cfg.gain);
      w1_r    <= w0_r;
      rgb1_r  <= rgb0_r;
    end
    if (en[2]) begin
      x2_r   <= x2;
      sqp2_r <= (2 * Q_W)'(x2) * (2 * Q_W)'(x2);
      t2_r   <= TW'({ONE_Q, 1'b0}) + TW'(ONE_Q) - TW'({x2, 1'b0});
      w2_r   <= w1_r;
      rgb2_r <= rgb1_r;
    end
    if (en[3]) begin
      x3_r   <= x2_r;
      smp3_r <= SMW'(sq3) * SMW'(t2_r);
      w3_r   <= w2_r;
      rgb3_r <= rgb2_r;
    end
    if (en[4]) begin
      w4_r   <= cfg.mode[0] ? bsum[8 +: Q_W] : w3_r;
      rgb4_r <= rgb3_r;
    end
  end

  assign out_valid = v_r[4];
  assign work      = w4_r;
  assign rgb_out   = rgb4_r;

endmodule

`default_nettype wire

>>> rtl/sftr_color.sv
// Output stages: duotone mapping and blend with the original, or grey replication.
`default_nettype none

module sftr_color
  import sftr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  cfg_t           cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [Q_W-1:0] work,
  input  rgb_t           rgb_in,
  output logic           out_valid,
  input  logic           out_ready,
  output rgb_t           pix
);

  localparam int DW = Q_W + 9;

  logic v1_r, v2_r;
  logic en1, en2;

  logic [DW-1:0] dsum [3];
  logic [DW-1:0] gsum;
  logic [16:0]   osum [3];
  logic [8:0]    r_w;

  rgb_t       duo1_r;
  rgb_t       orig1_r;
  logic [7:0] grey1_r;
  rgb_t       pix2_r;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign r_w  = sat256(cfg.recolor);
  assign gsum = DW'(work) * DW'(255) + DW'(HALF_Q);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dsum[c] = DW'(cfg.ink[c]) * DW'(ONE_Q - work) + DW'(cfg.paper[c]) * DW'(work)
              + DW'(HALF_Q);
      osum[c] = 17'(orig1_r[c]) * 17'(W_FULL - r_w) + 17'(duo1_r[c]) * 17'(r_w) + 17'(128);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int c = 0; c < 3; c++) begin
        duo1_r[c] <= dsum[c][FRAC_BITS +: 8];
      end
      grey1_r <= gsum[FRAC_BITS +: 8];
      orig1_r <= rgb_in;
    end
    if (en2) begin
      for (int c = 0; c < 3; c++) begin
        pix2_r[c] <= cfg.mode[1] ? osum[c][8 +: 8] : grey1_r;
      end
    end
  end

  assign out_valid = v2_r;
  assign pix       = pix2_r;

endmodule

`default_nettype wire

>>> rtl/scan_pixel_flatfield_tone_recolor_unit.sv
// Top level of the scan pixel flat-field, tone and recolor unit with its register file.
`default_nettype none

// One pixel request per clock is taken and one result leaves per clock while the output
// side does not stall; every request passes through thirteen register stages. The depth
// is set by the flat-field divider, a restoring divider of four stages that each settle
// three quotient bits, together with two front stages, five blend and tone stages and
// two color stages.
// Each stage holds a valid bit and only stops when it is full and the stage after it
// stops, so bubbles are squeezed out and in_stall rises only when every stage holds a
// request and out_stall is high. Luma is carried as a 12-bit fraction; the tone stage
// (mode bit 0) and the duotone stage (mode bit 1) are switched by the mode register,
// and with duotone off the grey value is replicated on all three channels. Registers
// sit at byte addresses 0, 4, ... 28 in the order flat strength, black point, stretch
// gain, curve mix, recolor strength, mode, paper tint, ink tint, are read back through
// prdata and must be written only while no pixel is in flight.
module scan_pixel_flatfield_tone_recolor_unit
  import sftr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_luma,
  input  logic [7:0]  in_backdrop,
  input  logic [7:0]  in_src_blue,
  input  logic [7:0]  in_src_green,
  input  logic [7:0]  in_src_red,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red
);

  logic [8:0]  flat_r;
  logic [11:0] black_r;
  logic [17:0] gain_r;
  logic [8:0]  mix_r;
  logic [8:0]  recolor_r;
  logic [1:0]  mode_r;
  logic [23:0] paper_r;
  logic [23:0] ink_r;

  logic       wr_en;
  logic [2:0] reg_idx;
  cfg_t       cfg;

  // Register file. Only whole-word writes matter; the low address bits are ignored.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flat_r    <= '0;
      black_r   <= '0;
      gain_r    <= 18'd256;
      mix_r     <= '0;
      recolor_r <= '0;
      mode_r    <= '0;
      paper_r   <= 24'hFFFFFF;
      ink_r     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FLAT:    flat_r    <= pwdata[8:0];
        REG_BLACK:   black_r   <= pwdata[11:0];
        REG_GAIN:    gain_r    <= pwdata[17:0];
        REG_MIX:     mix_r     <= pwdata[8:0];
        REG_RECOLOR: recolor_r <= pwdata[8:0];
        REG_MODE:    mode_r    <= pwdata[1:0];
        REG_PAPER:   paper_r   <= pwdata[23:0];
        REG_INK:     ink_r     <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLAT:    prdata = {23'd0, flat_r};
      REG_BLACK:   prdata = {20'd0, black_r};
      REG_GAIN:    prdata = {14'd0, gain_r};
      REG_MIX:     prdata = {23'd0, mix_r};
      REG_RECOLOR: prdata = {23'd0, recolor_r};
      REG_MODE:    prdata = {30'd0, mode_r};
      REG_PAPER:   prdata = {8'd0, paper_r};
      REG_INK:     prdata = {8'd0, ink_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.flat    = flat_r;
  assign cfg.black   = black_r;
  assign cfg.gain    = gain_r;
  assign cfg.mix     = mix_r;
  assign cfg.recolor = recolor_r;
  assign cfg.mode    = mode_r;
  assign cfg.paper   = paper_r;
  assign cfg.ink     = ink_r;

  // Datapath: front, divider, tone, color, chained by valid and ready.
  logic             fr_ready, fr_valid;
  logic [NUM_W-1:0] fr_num;
  logic [DEN_W-1:0] fr_den;
  logic             fr_ovf;
  logic [Q_W-1:0]   fr_work0;
  rgb_t             src_rgb, fr_rgb;

  logic             dv_ready, dv_valid;
  logic [Q_W-1:0]   dv_corr, dv_work0;
  rgb_t             dv_rgb;

  logic             tn_ready, tn_valid;
  logic [Q_W-1:0]   tn_work;
  rgb_t             tn_rgb;

  logic             co_ready;
  rgb_t             co_pix;

  assign src_rgb[0] = in_src_blue;
  assign src_rgb[1] = in_src_green;
  assign src_rgb[2] = in_src_red;

  sftr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (fr_ready),
    .luma      (in_luma),
    .backdrop  (in_backdrop),
    .src       (src_rgb),
    .out_valid (fr_valid),
    .out_ready (dv_ready),
    .num       (fr_num),
    .den       (fr_den),
    .ovf       (fr_ovf),
    .work0     (fr_work0),
    .rgb       (fr_rgb)
  );

  sftr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (dv_ready),
    .num       (fr_num),
    .den       (fr_den),
    .ovf       (fr_ovf),
    .work0_in  (fr_work0),
    .rgb_in    (fr_rgb),
    .out_valid (dv_valid),
    .out_ready (tn_ready),
    .corr      (dv_corr),
    .work0_out (dv_work0),
    .rgb_out   (dv_rgb)
  );

  sftr_tone u_tone (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (dv_valid),
    .in_ready  (tn_ready),
    .corr      (dv_corr),
    .work0     (dv_work0),
    .rgb_in    (dv_rgb),
    .out_valid (tn_valid),
    .out_ready (co_ready),
    .work      (tn_work),
    .rgb_out   (tn_rgb)
  );

  sftr_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (tn_valid),
    .in_ready  (co_ready),
    .work      (tn_work),
    .rgb_in    (tn_rgb),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .pix       (co_pix)
  );

  assign in_stall  = !fr_ready;
  assign out_blue  = co_pix[0];
  assign out_green = co_pix[1];
  assign out_red   = co_pix[2];

  // With the last stage empty or draining, the ready chain must reach the input.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the output stage can move");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
